/* hdl/fqkr_pkg.sv */
package fqkr_pkg;

    // default queue depth
    localparam int DEF_QUEUE_DEPTH = 16;

    // fixed field widths
    localparam int WORD_W      = 16;
    localparam int CMD_W       = 2;
    localparam int COUNT_OUT_W = 5;

    typedef logic [CMD_W-1:0]       t_cmd;
    typedef logic [WORD_W-1:0]      t_word;
    typedef logic [COUNT_OUT_W-1:0] t_count_out;

    // command codes
    localparam t_cmd CMD_PUSH   = 2'd0;
    localparam t_cmd CMD_POP    = 2'd1;
    localparam t_cmd CMD_FIND   = 2'd2;
    localparam t_cmd CMD_REMOVE = 2'd3;

    // one stored entry
    typedef struct packed {
        t_word id;
        t_word hnd;
    } t_entry;

    // result handed from the core to the output stage
    typedef struct packed {
        logic       ok;
        t_entry     entry;
        t_count_out count;
        logic       empty;
    } t_result;

endpackage

/* hdl/fqkr_if.sv */
interface fqkr_req_if import fqkr_pkg::*; ();
    logic  valid;
    logic  ready;
    t_cmd  cmd;
    t_word proc_id;
    t_word proc_handle;

    modport source (output valid, output cmd, output proc_id, output proc_handle,
                    input ready);
    modport sink   (input valid, input cmd, input proc_id, input proc_handle,
                    output ready);
endinterface

interface fqkr_rsp_if import fqkr_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       ok;
    t_word      id_out;
    t_word      handle_out;
    t_count_out count_out;
    logic       is_empty;

    modport source (output valid, output ok, output id_out, output handle_out,
                    output count_out, output is_empty, input ready);
    modport sink   (input valid, input ok, input id_out, input handle_out,
                    input count_out, input is_empty, output ready);
endinterface

/* hdl/fqkr_core.sv */
module fqkr_core import fqkr_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_cmd    i_cmd,
    input  t_word   i_key,
    input  t_word   i_hnd,
    output logic    o_idle,
    output logic    o_res_valid,
    output t_result o_res,
    input  logic    i_res_take
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_ADDR  = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_POP   = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // circular address step forward
    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] a);
        f_inc = (a == LAST_ADDR) ? '0 : a + 1'b1;
    endfunction

    // circular address step back
    function automatic logic [PW-1:0] f_dec(input logic [PW-1:0] a);
        f_dec = (a == '0) ? LAST_ADDR : a - 1'b1;
    endfunction

    // entry store, position 0 of the queue sits at r_head
    t_entry mem [QUEUE_DEPTH];

    logic          mem_we;
    logic [PW-1:0] mem_wa;
    t_entry        mem_wd;
    logic          mem_re;
    logic [PW-1:0] mem_ra;
    t_entry        r_rd_data;

    logic [2:0]    r_state,     n_state;
    logic [PW-1:0] r_head,      n_head;
    logic [PW-1:0] r_tail,      n_tail;
    logic [CW-1:0] r_count,     n_count;
    logic          r_cmp_valid, n_cmp_valid;
    logic          r_wr_pend,   n_wr_pend;

    t_cmd          r_cmd,       n_cmd;
    t_word         r_key,       n_key;
    logic [CW-1:0] r_iss_idx,   n_iss_idx;
    logic [PW-1:0] r_iss_addr,  n_iss_addr;
    logic [CW-1:0] r_cmp_idx,   n_cmp_idx;
    logic [PW-1:0] r_cmp_addr,  n_cmp_addr;
    logic [CW-1:0] r_src_idx,   n_src_idx;
    logic [PW-1:0] r_src_addr,  n_src_addr;
    logic [PW-1:0] r_wr_addr,   n_wr_addr;
    logic [PW-1:0] r_pend_addr, n_pend_addr;
    logic          r_res_ok,    n_res_ok;
    t_entry        r_res_entry, n_res_entry;

    // sequencer and memory port control
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_cmp_valid = r_cmp_valid;
        n_wr_pend   = r_wr_pend;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_iss_idx   = r_iss_idx;
        n_iss_addr  = r_iss_addr;
        n_cmp_idx   = r_cmp_idx;
        n_cmp_addr  = r_cmp_addr;
        n_src_idx   = r_src_idx;
        n_src_addr  = r_src_addr;
        n_wr_addr   = r_wr_addr;
        n_pend_addr = r_pend_addr;
        n_res_ok    = r_res_ok;
        n_res_entry = r_res_entry;
        mem_we      = 1'b0;
        mem_wa      = r_tail;
        mem_wd      = '{id: i_key, hnd: i_hnd};
        mem_re      = 1'b0;
        mem_ra      = r_head;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd       = i_cmd;
                    n_key       = i_key;
                    n_res_ok    = 1'b0;
                    n_res_entry = '0;
                    n_iss_idx   = '0;
                    n_iss_addr  = r_head;
                    n_cmp_valid = 1'b0;
                    case (i_cmd)
                        CMD_PUSH: begin
                            // append at the tail unless full
                            if (r_count != FULL_COUNT) begin
                                mem_we   = 1'b1;
                                n_tail   = f_inc(r_tail);
                                n_count  = r_count + 1'b1;
                                n_res_ok = 1'b1;
                            end
                            n_state = S_DONE;
                        end
                        CMD_POP: begin
                            if (r_count != '0) begin
                                mem_re  = 1'b1;
                                n_state = S_POP;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        CMD_FIND, CMD_REMOVE: begin
                            n_state = (r_count != '0) ? S_SCAN : S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_POP: begin
                // head entry is in the read register
                n_res_ok    = 1'b1;
                n_res_entry = r_rd_data;
                n_head      = f_inc(r_head);
                n_count     = r_count - 1'b1;
                n_state     = S_DONE;
            end

            S_SCAN: begin
                // issue one read a cycle, compare the one read last cycle
                if (r_iss_idx != r_count) begin
                    mem_re     = 1'b1;
                    mem_ra     = r_iss_addr;
                    n_iss_idx  = r_iss_idx + 1'b1;
                    n_iss_addr = f_inc(r_iss_addr);
                end
                n_cmp_valid = (r_iss_idx != r_count);
                n_cmp_idx   = r_iss_idx;
                n_cmp_addr  = r_iss_addr;
                if (r_cmp_valid && (r_rd_data.id == r_key)) begin
                    n_res_ok    = 1'b1;
                    n_res_entry = r_rd_data;
                    if (r_cmd == CMD_FIND) begin
                        n_state = S_DONE;
                    end else begin
                        n_state    = S_SHIFT;
                        n_wr_addr  = r_cmp_addr;
                        n_src_addr = f_inc(r_cmp_addr);
                        n_src_idx  = r_cmp_idx + 1'b1;
                        n_wr_pend  = 1'b0;
                    end
                end else if (!r_cmp_valid && (r_iss_idx == r_count)) begin
                    n_state = S_DONE;
                end
            end

            S_SHIFT: begin
                // write back the entry read last cycle one place nearer the head
                if (r_wr_pend) begin
                    mem_we = 1'b1;
                    mem_wa = r_pend_addr;
                    mem_wd = r_rd_data;
                end
                if (r_src_idx != r_count) begin
                    mem_re      = 1'b1;
                    mem_ra      = r_src_addr;
                    n_src_idx   = r_src_idx + 1'b1;
                    n_src_addr  = f_inc(r_src_addr);
                    n_wr_addr   = r_src_addr;
                    n_pend_addr = r_wr_addr;
                end
                n_wr_pend = (r_src_idx != r_count);
                if ((r_src_idx == r_count) && !r_wr_pend) begin
                    n_count = r_count - 1'b1;
                    n_tail  = f_dec(r_tail);
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_cmp_valid <= 1'b0;
            r_wr_pend   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_cmp_valid <= n_cmp_valid;
            r_wr_pend   <= n_wr_pend;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_key       <= n_key;
        r_iss_idx   <= n_iss_idx;
        r_iss_addr  <= n_iss_addr;
        r_cmp_idx   <= n_cmp_idx;
        r_cmp_addr  <= n_cmp_addr;
        r_src_idx   <= n_src_idx;
        r_src_addr  <= n_src_addr;
        r_wr_addr   <= n_wr_addr;
        r_pend_addr <= n_pend_addr;
        r_res_ok    <= n_res_ok;
        r_res_entry <= n_res_entry;
    end

    // entry memory, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_ra];
        end
    end

    // result towards the output stage
    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res.ok    = r_res_ok;
    assign o_res.entry = r_res_entry;
    assign o_res.count = COUNT_OUT_W'(r_count);
    assign o_res.empty = (r_count == '0);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("entry count above queue depth");

    a_no_port_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_wa != mem_ra))
        else $error("read and write to the same entry in one cycle");

    a_empty_pointers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && (r_count == '0)) |-> (r_head == r_tail))
        else $error("head and tail differ on an empty queue");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && !i_res_take) |=> ((r_state == S_DONE) && $stable(r_count)))
        else $error("result left before it was taken");
`endif

endmodule

/* hdl/fifo_queue_with_key_removal_top.sv */
// channel  | dir | handshake            | payload
// i_req    | in  | valid / ready        | cmd, proc_id, proc_handle
// o_rsp    | out | valid / ready        | ok, id_out, handle_out, count_out, is_empty
//
// find and remove walk over the entry memory, which has one read port
// reset is synchronous, active low, and empties the queue at once
// a request is taken whenever the sequencer is idle, even while a response waits
// a stalled response holds the sequencer in its final state, not the queue contents
module fifo_queue_with_key_removal_top import fqkr_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fqkr_req_if.sink    i_req,
    fqkr_rsp_if.source  o_rsp
);

    logic    core_idle;
    logic    res_valid;
    t_result res;
    logic    slot_free;

    logic    r_out_valid;
    t_result r_out;

    // request side
    assign i_req.ready = core_idle;
    assign slot_free   = !r_out_valid || o_rsp.ready;

    fqkr_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_req.valid && core_idle),
        .i_cmd       (i_req.cmd),
        .i_key       (i_req.proc_id),
        .i_hnd       (i_req.proc_handle),
        .o_idle      (core_idle),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (slot_free)
    );

    // response valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && slot_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // response payload
    always_ff @(posedge i_clk) begin
        if (res_valid && slot_free) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.ok         = r_out.ok;
    assign o_rsp.id_out     = r_out.entry.id;
    assign o_rsp.handle_out = r_out.entry.hnd;
    assign o_rsp.count_out  = r_out.count;
    assign o_rsp.is_empty   = r_out.empty;

endmodule

/* tb/fifo_queue_with_key_removal_top_tb.sv */
`timescale 1ns / 1ps

module fifo_queue_with_key_removal_top_tb;
    import fqkr_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 8;
    localparam int QUEUE_DEPTH    = DEF_QUEUE_DEPTH;
    localparam int DIR_ROWS       = 26;
    localparam int RAND_PER_PHASE = 642;
    localparam int BURST_LEN      = 40;
    localparam int KEY_POOL_N     = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 5000;

    // one row of the directed table
    typedef struct packed {
        t_cmd    cmd;
        t_word   id;
        t_word   hnd;
        logic    typed;
        t_result res;
    } t_req_row;

    logic clk = 1'b0;
    logic rst_n;

    fqkr_req_if req_if ();
    fqkr_rsp_if rsp_if ();

    fifo_queue_with_key_removal_top #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // clock
    always #(CLK_PERIOD / 2) clk = ~clk;

    // queue mirror used for prediction
    t_word       q_ids  [QUEUE_DEPTH];
    t_word       q_hnds [QUEUE_DEPTH];
    int          q_len = 0;

    t_result     expected_rsp_q [$];
    int unsigned mismatch_count = 0;

    // typed expectation travelling with the request on offer
    logic        dir_typed;
    t_result     dir_expect;

    // idling and hold-off control
    int          snd_idle_pct = 0;
    int          rcv_idle_pct = 0;
    int          hold_requests = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          stall_cycles = 0;

    // run statistics
    int unsigned cmd_seen [4];
    int unsigned cmd_ok   [4];
    int          deepest = 0;
    int unsigned empty_hits = 0;

    t_word       key_pool [KEY_POOL_N];

    // apply one request to the mirror and return the response it should give
    function automatic t_result queue_apply(t_cmd c, t_word key, t_word h);
        t_result r;
        int      pos;
        r   = '0;
        pos = -1;
        case (c)
            CMD_PUSH: begin
                if (q_len < QUEUE_DEPTH) begin
                    q_ids[q_len]  = key;
                    q_hnds[q_len] = h;
                    q_len++;
                    r.ok = 1'b1;
                end
            end
            CMD_POP: begin
                if (q_len > 0)
                    pos = 0;
            end
            default: begin
                for (int i = 0; i < q_len; i++)
                    if (pos < 0 && q_ids[i] == key)
                        pos = i;
            end
        endcase
        if (pos >= 0) begin
            r.ok        = 1'b1;
            r.entry.id  = q_ids[pos];
            r.entry.hnd = q_hnds[pos];
            // pop and remove close the gap, find leaves the queue alone
            if (c != CMD_FIND) begin
                for (int i = pos; i + 1 < q_len; i++) begin
                    q_ids[i]  = q_ids[i + 1];
                    q_hnds[i] = q_hnds[i + 1];
                end
                q_len--;
            end
        end
        r.count = t_count_out'(q_len);
        r.empty = (q_len == 0);
        return r;
    endfunction

    function automatic t_req_row dir_row(t_cmd c, t_word id, t_word h, logic typed,
                                         logic ok, t_word rid, t_word rhnd, int cnt);
        t_req_row row;
        row.cmd             = c;
        row.id              = id;
        row.hnd             = h;
        row.typed           = typed;
        row.res.ok          = ok;
        row.res.entry.id    = rid;
        row.res.entry.hnd   = rhnd;
        row.res.count       = t_count_out'(cnt);
        row.res.empty       = (cnt == 0);
        return row;
    endfunction

    task automatic report_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    // offer one request and return at the edge where it is taken
    task automatic send_request(t_cmd c, t_word id, t_word h, logic typed, t_result res);
        while ($urandom_range(99) < snd_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.cmd         <= c;
        req_if.proc_id     <= id;
        req_if.proc_handle <= h;
        dir_typed          <= typed;
        dir_expect         <= res;
        do @(posedge clk); while (!req_if.ready);
    endtask

    // response sink with random stalls and long hold-offs on demand
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
            hold_left = 0;
        end else if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // response check first, then prediction for a request taken at the same edge
    always @(posedge clk) begin
        t_result got;
        t_result pred;
        t_result want;
        if (rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                got.ok        = rsp_if.ok;
                got.entry.id  = rsp_if.id_out;
                got.entry.hnd = rsp_if.handle_out;
                got.count     = rsp_if.count_out;
                got.empty     = rsp_if.is_empty;
                if (expected_rsp_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: response with none outstanding, got %h", $time, got);
                end else begin
                    want = expected_rsp_q[0];
                    expected_rsp_q.delete(0);
                    report_field("ok", t_word'(want.ok), t_word'(got.ok));
                    report_field("id_out", want.entry.id, got.entry.id);
                    report_field("handle_out", want.entry.hnd, got.entry.hnd);
                    report_field("count_out", t_word'(want.count), t_word'(got.count));
                    report_field("is_empty", t_word'(want.empty), t_word'(got.empty));
                end
            end
            if (req_if.valid && req_if.ready) begin
                pred = queue_apply(req_if.cmd, req_if.proc_id, req_if.proc_handle);
                want = dir_typed ? dir_expect : pred;
                expected_rsp_q = {expected_rsp_q, want};
                cmd_seen[req_if.cmd]++;
                if (want.ok)
                    cmd_ok[req_if.cmd]++;
                if (q_len > deepest)
                    deepest = q_len;
                if (q_len == 0)
                    empty_hits++;
            end
        end
    end

    // watchdog on cycles with no request or response moving
    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("fifo_queue_with_key_removal_top_tb NOT OK");
                $finish;
            end
        end
    end

    initial begin
        t_req_row dir_table [DIR_ROWS];
        t_cmd     c;
        t_word    id;
        int       pick;
        logic     filling;

        // known values from time zero
        rst_n              = 1'b0;
        req_if.valid       = 1'b0;
        req_if.cmd         = CMD_PUSH;
        req_if.proc_id     = '0;
        req_if.proc_handle = '0;
        dir_typed          = 1'b0;
        dir_expect         = '0;

        // empty queue, fill to full with duplicate ids, reject, then find, remove, pop and a missed find
        dir_table = '{
            dir_row(CMD_POP,    16'h0000, 16'h0000, 1, 0, 16'h0000, 16'h0000, 0),
            dir_row(CMD_FIND,   16'h1234, 16'h0000, 1, 0, 16'h0000, 16'h0000, 0),
            dir_row(CMD_REMOVE, 16'h1234, 16'h0000, 1, 0, 16'h0000, 16'h0000, 0),
            dir_row(CMD_PUSH,   16'hFFFF, 16'h0000, 1, 1, 16'h0000, 16'h0000, 1),
            dir_row(CMD_PUSH,   16'h0000, 16'hFFFF, 1, 1, 16'h0000, 16'h0000, 2),
            dir_row(CMD_PUSH,   16'h1234, 16'h5678, 1, 1, 16'h0000, 16'h0000, 3),
            dir_row(CMD_PUSH,   16'h8000, 16'h0001, 1, 1, 16'h0000, 16'h0000, 4),
            dir_row(CMD_PUSH,   16'h0001, 16'h8000, 1, 1, 16'h0000, 16'h0000, 5),
            dir_row(CMD_PUSH,   16'hAAAA, 16'h5555, 1, 1, 16'h0000, 16'h0000, 6),
            dir_row(CMD_PUSH,   16'h5555, 16'hAAAA, 1, 1, 16'h0000, 16'h0000, 7),
            dir_row(CMD_PUSH,   16'h1234, 16'h9ABC, 1, 1, 16'h0000, 16'h0000, 8),
            dir_row(CMD_PUSH,   16'h7F7F, 16'h0F0F, 1, 1, 16'h0000, 16'h0000, 9),
            dir_row(CMD_PUSH,   16'hC3C3, 16'h3C3C, 1, 1, 16'h0000, 16'h0000, 10),
            dir_row(CMD_PUSH,   16'h0101, 16'hFEFE, 1, 1, 16'h0000, 16'h0000, 11),
            dir_row(CMD_PUSH,   16'h4000, 16'h0002, 1, 1, 16'h0000, 16'h0000, 12),
            dir_row(CMD_PUSH,   16'h0002, 16'h4000, 1, 1, 16'h0000, 16'h0000, 13),
            dir_row(CMD_PUSH,   16'h2468, 16'h1357, 1, 1, 16'h0000, 16'h0000, 14),
            dir_row(CMD_PUSH,   16'h8421, 16'h7BDE, 1, 1, 16'h0000, 16'h0000, 15),
            dir_row(CMD_PUSH,   16'hFFFF, 16'hFFFF, 1, 1, 16'h0000, 16'h0000, 16),
            dir_row(CMD_PUSH,   16'h7777, 16'h0000, 1, 0, 16'h0000, 16'h0000, 16),
            dir_row(CMD_FIND,   16'h1234, 16'h0000, 1, 1, 16'h1234, 16'h5678, 16),
            dir_row(CMD_REMOVE, 16'h1234, 16'h0000, 1, 1, 16'h1234, 16'h5678, 15),
            dir_row(CMD_REMOVE, 16'hFFFF, 16'h0000, 1, 1, 16'hFFFF, 16'h0000, 14),
            dir_row(CMD_REMOVE, 16'hFFFF, 16'h0000, 0, 0, 16'h0000, 16'h0000, 0),
            dir_row(CMD_POP,    16'h0000, 16'h0000, 0, 0, 16'h0000, 16'h0000, 0),
            dir_row(CMD_FIND,   16'h9999, 16'h0000, 1, 0, 16'h0000, 16'h0000, 12)
        };

        // reset
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < DIR_ROWS; r++)
            send_request(dir_table[r].cmd, dir_table[r].id, dir_table[r].hnd,
                         dir_table[r].typed, dir_table[r].res);
        req_if.valid <= 1'b0;
        while (expected_rsp_q.size() != 0) @(posedge clk);

        // random phases: sender idles little, then receiver idles little, then no idling
        for (int ph = 0; ph < 3; ph++) begin
            snd_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 54 : 0;
            rcv_idle_pct = (ph == 0) ? 54 : (ph == 1) ? 6 : 0;
            for (int k = 0; k < KEY_POOL_N; k++)
                key_pool[k] = t_word'($urandom);
            // long receiver hold-off while requests keep coming
            if (ph != 1)
                hold_requests++;
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                // alternate bursts that fill and drain the queue
                filling = ((n / BURST_LEN) % 2) == 0;
                pick    = $urandom_range(99);
                if (filling)
                    c = (pick < 55) ? CMD_PUSH : (pick < 70) ? CMD_POP :
                        (pick < 85) ? CMD_FIND : CMD_REMOVE;
                else
                    c = (pick < 20) ? CMD_PUSH : (pick < 50) ? CMD_POP :
                        (pick < 70) ? CMD_FIND : CMD_REMOVE;
                // ids mostly from a small pool so finds and removes hit
                id = ($urandom_range(99) < 85) ? key_pool[$urandom_range(KEY_POOL_N - 1)]
                                               : t_word'($urandom);
                send_request(c, id, t_word'($urandom), 1'b0, '0);
            end
            // sender pauses until every response is back
            req_if.valid <= 1'b0;
            while (expected_rsp_q.size() != 0) @(posedge clk);
        end

        // let any stray response show up
        repeat (TAIL_CYCLES) @(posedge clk);

        $write("requests: push %0d (%0d taken), pop %0d (%0d hit), ",
               cmd_seen[CMD_PUSH], cmd_ok[CMD_PUSH], cmd_seen[CMD_POP], cmd_ok[CMD_POP]);
        $display("find %0d (%0d hit), remove %0d (%0d hit)",
                 cmd_seen[CMD_FIND], cmd_ok[CMD_FIND], cmd_seen[CMD_REMOVE], cmd_ok[CMD_REMOVE]);
        $display("deepest queue %0d of %0d, emptied %0d times, %0d mismatches",
                 deepest, QUEUE_DEPTH, empty_hits, mismatch_count);
        if (mismatch_count == 0)
            $display("fifo_queue_with_key_removal_top_tb OK");
        else
            $display("fifo_queue_with_key_removal_top_tb NOT OK");
        $finish;
    end

endmodule
